>>> sv/rhh_pkg.sv
// Shared types, sizes and codes for the Robin Hood hash table.
// Used by rhh_core and robin_hood_hash_table; depends on nothing else.
package rhh_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int PRB_W = IDX_W + 1;
  localparam int LIMIT_W = 6;
  localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  localparam int HASH_W = 64;
  localparam int OWNER_W = 16;
  localparam int LOC_W = 16;
  localparam int STATUS_W = 2;
  localparam int USED_W = 7;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RESET = 6'd48;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LOAD_LIMIT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_PROBE_LIMIT = 2'd3;

  // Slot payload held in the memory; valid bits live in flip-flops.
  typedef struct packed {
    logic [HASH_W-1:0]  hash;
    logic [OWNER_W-1:0] owner;
    logic [LOC_W-1:0]   location;
    logic [IDX_W-1:0]   probe_dist;
  } slot_t;

endpackage

>>> sv/rhh_core.sv
// Probe engine of the Robin Hood hash table: slot memory, valid bits,
// entry count, probe sequencer and result register. Depends on rhh_pkg.
module rhh_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [rhh_pkg::LIMIT_W-1:0]   load_limit,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_operation,
  input  logic [rhh_pkg::HASH_W-1:0]    in_key_hash,
  input  logic [rhh_pkg::OWNER_W-1:0]   in_owner_id,
  input  logic [rhh_pkg::LOC_W-1:0]     in_entry_location,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rhh_pkg::STATUS_W-1:0]  out_status,
  output logic [rhh_pkg::LOC_W-1:0]     out_found_location,
  output logic [rhh_pkg::USED_W-1:0]    out_entries_used
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PROBE = 2'd1;
  localparam logic [1:0] S_DONE  = 2'd2;

  localparam logic [rhh_pkg::IDX_W-1:0] LAST_STEP = {rhh_pkg::IDX_W{1'b1}};

  logic [1:0] state_r, state_nxt;

  rhh_pkg::slot_t mem [rhh_pkg::TABLE_ENTRIES];
  rhh_pkg::slot_t rd_data_r;
  rhh_pkg::slot_t wr_data;
  logic [rhh_pkg::IDX_W-1:0] rd_addr;
  logic rd_en, wr_en;

  logic [rhh_pkg::TABLE_ENTRIES-1:0] valid_r;
  logic [rhh_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  logic op_r, op_nxt;
  logic [rhh_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic [rhh_pkg::IDX_W-1:0] step_r, step_nxt;
  logic [rhh_pkg::PRB_W-1:0] probe_r, probe_nxt;
  logic [rhh_pkg::HASH_W-1:0] c_hash_r, c_hash_nxt;
  logic [rhh_pkg::OWNER_W-1:0] c_owner_r, c_owner_nxt;
  logic [rhh_pkg::LOC_W-1:0] c_loc_r, c_loc_nxt;

  logic [rhh_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [rhh_pkg::LOC_W-1:0] res_loc_r, res_loc_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [rhh_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [rhh_pkg::LOC_W-1:0] out_loc_r, out_loc_nxt;
  logic [rhh_pkg::USED_W-1:0] out_used_r, out_used_nxt;

  logic fin;
  logic [rhh_pkg::STATUS_W-1:0] fin_status;
  logic [rhh_pkg::LOC_W-1:0] fin_loc;
  logic out_free, slot_v, longer, match, at_limit, is_full;

  assign out_free = !out_valid_r || out_ready;
  assign slot_v = valid_r[idx_r];
  assign longer = probe_r > {1'b0, rd_data_r.probe_dist};
  assign match = (rd_data_r.hash == c_hash_r) && (rd_data_r.owner == c_owner_r);
  assign at_limit = rhh_pkg::CMP_W'(cnt_r) >= rhh_pkg::CMP_W'(load_limit);
  assign is_full = cnt_r >= rhh_pkg::CNT_W'(rhh_pkg::TABLE_ENTRIES);

  assign in_ready = (state_r == S_IDLE);
  assign wr_data = '{hash: c_hash_r, owner: c_owner_r, location: c_loc_r,
                     probe_dist: probe_r[rhh_pkg::IDX_W-1:0]};

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    idx_nxt = idx_r;
    step_nxt = step_r;
    probe_nxt = probe_r;
    c_hash_nxt = c_hash_r;
    c_owner_nxt = c_owner_r;
    c_loc_nxt = c_loc_r;
    res_status_nxt = res_status_r;
    res_loc_nxt = res_loc_r;
    cnt_nxt = cnt_r;
    rd_en = 1'b0;
    rd_addr = idx_r + 1'b1;
    wr_en = 1'b0;
    fin = 1'b0;
    fin_status = rhh_pkg::ST_OK;
    fin_loc = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt = in_operation;
          c_hash_nxt = in_key_hash;
          c_owner_nxt = in_owner_id;
          c_loc_nxt = in_entry_location;
          res_loc_nxt = '0;
          if (in_operation == rhh_pkg::OP_INSERT && at_limit) begin
            res_status_nxt = rhh_pkg::ST_LOAD_LIMIT;
            state_nxt = S_DONE;
          end else if (in_operation == rhh_pkg::OP_INSERT && is_full) begin
            res_status_nxt = rhh_pkg::ST_PROBE_LIMIT;
            state_nxt = S_DONE;
          end else begin
            rd_en = 1'b1;
            rd_addr = in_key_hash[rhh_pkg::IDX_W-1:0];
            idx_nxt = in_key_hash[rhh_pkg::IDX_W-1:0];
            step_nxt = '0;
            probe_nxt = '0;
            state_nxt = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        if (op_r == rhh_pkg::OP_INSERT) begin
          if (!slot_v) begin
            wr_en = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
            fin = 1'b1;
            fin_status = rhh_pkg::ST_OK;
          end else begin
            // Robin Hood swap: take the slot, carry the resident onward
            if (longer) begin
              wr_en = 1'b1;
              c_hash_nxt = rd_data_r.hash;
              c_owner_nxt = rd_data_r.owner;
              c_loc_nxt = rd_data_r.location;
              probe_nxt = {1'b0, rd_data_r.probe_dist} + 1'b1;
            end else begin
              probe_nxt = probe_r + 1'b1;
            end
            if (step_r == LAST_STEP) begin
              fin = 1'b1;
              fin_status = rhh_pkg::ST_PROBE_LIMIT;
            end else begin
              rd_en = 1'b1;
            end
          end
        end else begin
          if (!slot_v || longer) begin
            fin = 1'b1;
            fin_status = rhh_pkg::ST_NOT_FOUND;
          end else if (match) begin
            fin = 1'b1;
            fin_status = rhh_pkg::ST_OK;
            fin_loc = rd_data_r.location;
          end else if (step_r == LAST_STEP) begin
            fin = 1'b1;
            fin_status = rhh_pkg::ST_NOT_FOUND;
          end else begin
            rd_en = 1'b1;
            probe_nxt = probe_r + 1'b1;
          end
        end
        if (fin) begin
          res_status_nxt = fin_status;
          res_loc_nxt = fin_loc;
          state_nxt = out_free ? S_IDLE : S_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
          step_nxt = step_r + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result register: load on finish or from the hold stage, drop on transfer
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_loc_nxt = out_loc_r;
    out_used_nxt = out_used_r;
    if (state_r == S_PROBE && fin && out_free) begin
      out_valid_nxt = 1'b1;
      out_status_nxt = fin_status;
      out_loc_nxt = fin_loc;
      out_used_nxt = rhh_pkg::USED_W'(cnt_nxt);
    end else if (state_r == S_DONE && out_free) begin
      out_valid_nxt = 1'b1;
      out_status_nxt = res_status_r;
      out_loc_nxt = res_loc_r;
      out_used_nxt = rhh_pkg::USED_W'(cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx_r] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (wr_en) begin
        valid_r[idx_r] <= 1'b1;
      end
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    idx_r <= idx_nxt;
    step_r <= step_nxt;
    probe_r <= probe_nxt;
    c_hash_r <= c_hash_nxt;
    c_owner_r <= c_owner_nxt;
    c_loc_r <= c_loc_nxt;
    res_status_r <= res_status_nxt;
    res_loc_r <= res_loc_nxt;
    out_status_r <= out_status_nxt;
    out_loc_r <= out_loc_nxt;
    out_used_r <= out_used_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_found_location = out_loc_r;
  assign out_entries_used = out_used_r;

endmodule

>>> sv/robin_hood_hash_table.sv
// Top level of the Robin Hood hash table: configuration register port and
// the probe engine. Depends on rhh_pkg and rhh_core.
//
//  channel   direction  handshake          payload
//  in_       input      in_valid/in_ready  operation, key_hash, owner_id,
//                                          entry_location
//  out_      output     out_valid/out_ready status, found_location,
//                                          entries_used
//  cfg       input      psel/penable/pready load_limit at byte address 0
//
// An accepted lookup or insert reads the home slot and then visits slots in
// turn, paced by the single slot memory port pair (read next slot, write
// current slot); refused inserts skip the memory and go to the hold stage.
// Reset clears the valid flip-flops and the entry count at once: no sweep.
// One item is in flight at a time; a held result stalls only the finish.
module robin_hood_hash_table (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rhh_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [rhh_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [rhh_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_operation,
  input  logic [rhh_pkg::HASH_W-1:0]        in_key_hash,
  input  logic [rhh_pkg::OWNER_W-1:0]       in_owner_id,
  input  logic [rhh_pkg::LOC_W-1:0]         in_entry_location,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rhh_pkg::STATUS_W-1:0]      out_status,
  output logic [rhh_pkg::LOC_W-1:0]         out_found_location,
  output logic [rhh_pkg::USED_W-1:0]        out_entries_used
);

  logic [rhh_pkg::LIMIT_W-1:0] load_limit_r;
  logic sel_limit;

  // Word index lies above the byte offset bits
  assign sel_limit = (paddr[rhh_pkg::CFG_ADDR_W-1] == 1'b0);
  assign pready = 1'b1;
  assign prdata = sel_limit ? rhh_pkg::CFG_DATA_W'(load_limit_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_limit_r <= rhh_pkg::LOAD_LIMIT_RESET;
    end else if (psel && penable && pwrite && sel_limit) begin
      load_limit_r <= pwdata[rhh_pkg::LIMIT_W-1:0];
    end
  end

  rhh_core u_core (
    .clk                (clk),
    .rst_n              (rst_n),
    .load_limit         (load_limit_r),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_key_hash        (in_key_hash),
    .in_owner_id        (in_owner_id),
    .in_entry_location  (in_entry_location),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_found_location (out_found_location),
    .out_entries_used   (out_entries_used)
  );

endmodule
